// ----- rtl/core/h263_gap_filler_filter_defines.svh -----
// ----------------------------------------------------------------------------
// H.263 gap filler filter assertion macros
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef H263_GAP_FILLER_FILTER_DEFINES_SVH
`define H263_GAP_FILLER_FILTER_DEFINES_SVH

// Same-cycle implication.
`define HGGF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hggf: same-cycle check failed");

// Next-cycle implication.
`define HGGF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hggf: next-cycle check failed");

`endif

// ----- rtl/core/hggf_pkg.sv -----
// ----------------------------------------------------------------------------
// H.263 gap filler filter package
// Types and fixed constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package hggf_pkg;

  localparam int unsigned PASS_W = 6;

  localparam logic [7:0] CHAR_M = 8'h6d;
  localparam logic [7:0] CHAR_D = 8'h64;
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_T = 8'h74;

  localparam logic [7:0] AUDIO_MARK = 8'h3c;
  localparam int unsigned AUDIO_TAP1 = 32;
  localparam int unsigned AUDIO_TAP2 = 64;

  localparam logic [7:0] PIC_CODE_LO = 8'h80;
  localparam logic [7:0] PIC_CODE_HI = 8'h83;

  localparam logic [1:0] TAG_TAIL = 2'd3;

  localparam logic [PASS_W-1:0] PASS_OFF = '0;
  localparam logic [PASS_W-1:0] PASS_ON  = PASS_W'(1);

  typedef struct packed {
    logic       full;
    logic [7:0] head;
    logic       is_mdat;
    logic       is_audio;
    logic       is_pic;
    logic [7:0] tr;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/core/h263_gap_filler_filter.sv -----
// ----------------------------------------------------------------------------
// H.263 gap filler filter
// Lookahead byte filter that strips mdat tags, skips audio and counts gaps.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and returns one result per byte,
// sustained at one item per clock while the output is ready; when it is not,
// the two-entry queue fills and in_ready_o drops. An accepted byte's entry is
// written into the queue and is then loaded into the output register when the
// back end pops it, once the output register is empty or being taken. The back
// end updates the output mode and the 32-bit picture number on each pop. The
// first WINDOW_BYTES-1 results are all zero while the window fills.
`default_nettype none

module h263_gap_filler_filter #(
  parameter int unsigned WINDOW_BYTES = 80,
  parameter int unsigned AUDIO_SKIP   = 33
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] stream_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            byte_valid_o,
  output logic [7:0]      byte_value_o,
  output logic [7:0]      dummy_frames_o
);

  hggf_pkg::item_t front_item;
  hggf_pkg::item_t queue_item;
  logic            queue_full;
  logic            queue_valid;
  logic            queue_pop;
  logic            in_accept;

  assign in_ready_o = !queue_full;
  assign in_accept  = in_valid_i && in_ready_o;

  hggf_front #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .stream_byte_i(stream_byte_i),
    .item_o       (front_item)
  );

  hggf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_accept),
    .item_i (front_item),
    .full_o (queue_full),
    .valid_o(queue_valid),
    .pop_i  (queue_pop),
    .item_o (queue_item)
  );

  hggf_back #(
    .AUDIO_SKIP(AUDIO_SKIP)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (queue_valid),
    .item_i        (queue_item),
    .pop_o         (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_valid_o  (byte_valid_o),
    .byte_value_o  (byte_value_o),
    .dummy_frames_o(dummy_frames_o)
  );

`include "h263_gap_filler_filter_defines.svh"

  `HGGF_ASSERT_IMPLIES(a_dummy_implies_pass, out_valid_o && (dummy_frames_o != 8'd0), byte_valid_o)
  `HGGF_ASSERT_IMPLIES(a_blank_byte_zero, out_valid_o && !byte_valid_o, byte_value_o == 8'd0)
  `HGGF_ASSERT_IMPLIES(a_full_queue_valid, !in_ready_o, queue_valid)
  `HGGF_ASSERT_NEXT(a_push_seen, in_accept, queue_valid)

endmodule

`default_nettype wire

// ----- rtl/core/hggf_front.sv -----
// ----------------------------------------------------------------------------
// H.263 gap filler filter front end
// Shifts bytes through the lookahead window and classifies the head byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hggf_front #(
  parameter int unsigned WINDOW_BYTES = 80
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    stream_byte_i,
  output hggf_pkg::item_t    item_o
);

  localparam int unsigned CNT_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_BYTES - 1);

  logic [7:0]       wnd_q [WINDOW_BYTES];
  logic [7:0]       wnd_d [WINDOW_BYTES];
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      wnd_d[i] = wnd_q[i+1];
    end
    wnd_d[WINDOW_BYTES-1] = stream_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        wnd_q[i] <= wnd_d[i];
      end
    end
  end

  assign cnt_d = (accept_i && (cnt_q != CNT_LAST)) ? cnt_q + CNT_W'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    item_o.full     = (cnt_q == CNT_LAST);
    item_o.head     = wnd_d[0];
    item_o.is_mdat  = (wnd_d[0] == hggf_pkg::CHAR_M) && (wnd_d[1] == hggf_pkg::CHAR_D) &&
                      (wnd_d[2] == hggf_pkg::CHAR_A) && (wnd_d[3] == hggf_pkg::CHAR_T);
    item_o.is_audio = (wnd_d[0] == hggf_pkg::AUDIO_MARK) &&
                      (wnd_d[hggf_pkg::AUDIO_TAP1] == hggf_pkg::AUDIO_MARK) &&
                      (wnd_d[hggf_pkg::AUDIO_TAP2] == hggf_pkg::AUDIO_MARK);
    item_o.is_pic   = (wnd_d[0] == 8'h00) && (wnd_d[1] == 8'h00) &&
                      (wnd_d[2] >= hggf_pkg::PIC_CODE_LO) &&
                      (wnd_d[2] <= hggf_pkg::PIC_CODE_HI);
    item_o.tr       = {wnd_d[2][1:0], wnd_d[3][7:2]};
  end

endmodule

`default_nettype wire

// ----- rtl/core/hggf_queue.sv -----
// ----------------------------------------------------------------------------
// H.263 gap filler filter queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hggf_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  hggf_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  input  wire logic       pop_i,
  output hggf_pkg::item_t item_o
);

  hggf_pkg::item_t mem_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hggf_back.sv -----
// ----------------------------------------------------------------------------
// H.263 gap filler filter back end
// Tracks output mode, tag deletion and picture numbering, and holds results.
// ----------------------------------------------------------------------------
`default_nettype none

module hggf_back #(
  parameter int unsigned AUDIO_SKIP = 33
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  hggf_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            byte_valid_o,
  output logic [7:0]      byte_value_o,
  output logic [7:0]      dummy_frames_o
);

  localparam logic [hggf_pkg::PASS_W-1:0] PASS_SKIP = hggf_pkg::PASS_W'(AUDIO_SKIP);

  logic [hggf_pkg::PASS_W-1:0] pass_q, pass_d, pass_eff;
  logic [1:0]                  tag_q, tag_d;
  logic [31:0]                 last_q, last_d;
  logic                        oval_q;
  logic                        bval_d;
  logic [7:0]                  bbyte_d, dum_d;

  logic        wrap;
  logic [31:0] pic, next, gap;
  logic [7:0]  pic_dum;
  logic [31:0] pic_last;

  assign pop_o = valid_i && (!oval_q || out_ready_i);

  always_comb begin
    wrap = (item_i.tr < last_q[7:0]);
    pic  = {last_q[31:8] + 24'(wrap), item_i.tr};
    next = last_q + 32'd1;
    gap  = pic - next;
    if (last_q == 32'd0) begin
      pic_last = pic;
      pic_dum  = 8'd0;
    end else if (pic > next) begin
      pic_last = pic;
      pic_dum  = (gap[31:8] != 24'd0) ? 8'hFF : gap[7:0];
    end else begin
      pic_last = next;
      pic_dum  = 8'd0;
    end
  end

  always_comb begin
    pass_d   = pass_q;
    tag_d    = tag_q;
    last_d   = last_q;
    bval_d   = 1'b0;
    bbyte_d  = 8'd0;
    dum_d    = 8'd0;
    pass_eff = item_i.is_audio ? PASS_SKIP : pass_q;
    priority if (!item_i.full) begin
      pass_d = pass_q;
    end else if (tag_q != 2'd0) begin
      tag_d = tag_q - 2'd1;
    end else if (item_i.is_mdat) begin
      pass_d = hggf_pkg::PASS_ON;
      tag_d  = hggf_pkg::TAG_TAIL;
    end else begin
      if (item_i.is_pic) begin
        pass_eff = hggf_pkg::PASS_ON;
        last_d   = pic_last;
        dum_d    = pic_dum;
      end
      bval_d  = (pass_eff == hggf_pkg::PASS_ON);
      bbyte_d = bval_d ? item_i.head : 8'd0;
      pass_d  = (pass_eff > hggf_pkg::PASS_ON) ? pass_eff - hggf_pkg::PASS_ON : pass_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= hggf_pkg::PASS_OFF;
      tag_q  <= 2'd0;
      last_q <= 32'd0;
      oval_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pass_q <= pass_d;
        tag_q  <= tag_d;
        last_q <= last_d;
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_valid_o   <= bval_d;
      byte_value_o   <= bbyte_d;
      dummy_frames_o <= dum_d;
    end
  end

  assign out_valid_o = oval_q;

endmodule

`default_nettype wire
